/* src/wrq_pkg.sv */
// Package for the watermark reorder queue: record types, sizes and the
// ordering and release functions shared by the cells and the top level.
// No dependencies.
package wrq_pkg;

  localparam int CAPACITY    = 64;
  // Release runs stop on an empty store, so a run can never exceed CAPACITY
  localparam int MAX_RESULTS = CAPACITY;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam int TAG_W = 16;
  localparam int REF_W = 16;
  localparam int POS_W = 31;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 72;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [REF_W-1:0] ref_id;
    logic             mapd;
    logic             proc;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Item under release: the watermark fields of the request that opened the run
  typedef struct packed {
    logic             flush;
    logic             proc;
    logic             mapd;
    logic [REF_W-1:0] ref_id;
    logic [POS_W-1:0] orig;
  } item_t;

  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_ent;
  } chain_cmd_t;

  typedef struct packed {
    logic occ;
    logic at_fill;
  } cell_ctl_t;

  // Rank: 0 processed mapped, 1 processed unmapped, 2 unprocessed
  function automatic logic [1:0] key_class(entry_t e);
    logic [1:0] c;
    if (!e.proc) c = 2'd2;
    else if (!e.mapd) c = 2'd1;
    else c = 2'd0;
    return c;
  endfunction

  // True when a sorts strictly after b
  function automatic logic key_after(entry_t a, entry_t b);
    logic [1:0] ca;
    logic [1:0] cb;
    logic       r;
    ca = key_class(a);
    cb = key_class(b);
    if (ca != cb) r = (ca > cb);
    else if (ca != 2'd0) r = 1'b0;
    else if (a.ref_id != b.ref_id) r = (a.ref_id > b.ref_id);
    else r = (a.pos > b.pos);
    return r;
  endfunction

  function automatic logic head_release(entry_t h, logic own, item_t it);
    logic r;
    if (own) r = 1'b0;
    else if (!h.proc) r = 1'b0;
    else if (!it.proc) r = 1'b1;
    else if (!h.mapd) r = 1'b0;
    else if (!it.mapd) r = 1'b1;
    else if (it.ref_id != h.ref_id) r = (it.ref_id > h.ref_id);
    else r = (it.orig > h.pos);
    return r;
  endfunction

endpackage

/* src/wrq_cell.sv */
// One slot of the sorted shift chain: holds an entry and an own-entry mark,
// takes a neighbour's entry on insert or pop. Depends on wrq_pkg.
module wrq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wrq_pkg::chain_cmd_t cmd,
  input  wrq_pkg::cell_ctl_t  ctl,
  input  logic                left_gt,
  input  wrq_pkg::entry_t     left_ent,
  input  wrq_pkg::entry_t     right_ent,
  input  logic                right_own,
  output wrq_pkg::entry_t     ent_o,
  output logic                own_o,
  output logic                gt_o
);
  import wrq_pkg::*;

  entry_t ent_r, ent_nxt;
  logic   own_r, own_nxt;

  assign gt_o  = ctl.occ && key_after(ent_r, cmd.new_ent);
  assign ent_o = ent_r;
  assign own_o = own_r;

  always_comb begin
    ent_nxt = ent_r;
    own_nxt = own_r;
    if (cmd.pop) begin
      ent_nxt = right_ent;
      own_nxt = right_own;
    end else if (cmd.ins) begin
      own_nxt = 1'b0;
      if (left_gt) begin
        // make room: shift the larger entry along
        ent_nxt = left_ent;
      end else if (gt_o || ctl.at_fill) begin
        ent_nxt = cmd.new_ent;
        own_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      own_r <= 1'b0;
    end else begin
      own_r <= own_nxt;
    end
  end

endmodule

/* src/wrq_chain.sv */
// Row of CAPACITY wrq_cell slots kept in sort order, head at slot 0.
// Depends on wrq_pkg and wrq_cell.
module wrq_chain (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wrq_pkg::chain_cmd_t     cmd,
  input  logic [wrq_pkg::CNT_W-1:0] count,
  output wrq_pkg::entry_t         head,
  output logic                    head_own,
  output wrq_pkg::entry_t         second,
  output logic                    second_own
);
  import wrq_pkg::*;

  entry_t ent   [CAPACITY];
  logic   own   [CAPACITY];
  logic   gt    [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    l_ent;
    entry_t    r_ent;
    logic      l_gt;
    logic      r_own;

    assign ctl.occ     = (CNT_W'(i) < count);
    assign ctl.at_fill = (CNT_W'(i) == count);

    if (i == 0) begin : g_first
      assign l_ent = '0;
      assign l_gt  = 1'b0;
    end else begin : g_mid
      assign l_ent = ent[i-1];
      assign l_gt  = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_ent = '0;
      assign r_own = 1'b0;
    end else begin : g_inner
      assign r_ent = ent[i+1];
      assign r_own = own[i+1];
    end

    wrq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .ctl       (ctl),
      .left_gt   (l_gt),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .right_own (r_own),
      .ent_o     (ent[i]),
      .own_o     (own[i]),
      .gt_o      (gt[i])
    );
  end

  assign head       = ent[0];
  assign head_own   = own[0];
  assign second     = ent[1];
  assign second_own = own[1];

endmodule

/* src/watermark_reorder_queue.sv */
// Watermark reorder queue top level: request handshake, release sequencer
// and output register around the wrq_chain. Depends on wrq_pkg, wrq_chain.
//
// Requests arrive on the in_ stream: in_tuser is the command (push or
// flush), in_tlast is batch_end, in_tdata carries the record. A push is
// sorted into a chain of CAPACITY cells in the cycle it is accepted; the
// chain is a row of slots that shift right to open a gap on insert and
// shift left when the head leaves.
// A push without batch_end gives no result. A push with
// batch_end or a flush enters a release run after its accepting cycle: the
// head is checked against the request's watermark and, when it qualifies,
// moved into the output register, one record per cycle while the receiver
// takes them; in_tready stays low during the run. A record shows on the
// out_ stream the cycle after it leaves the head, out_tlast on the final
// record of a run, out_tuser the sticky overflow flag as it stood for that
// run. A push into a full store is dropped and sets that flag until reset.
// When the receiver stalls, the held record waits in the output register
// and the run pauses; nothing is lost. Reset empties the store, clears the
// flag and out_tvalid, and the block accepts a request at once.
module watermark_reorder_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tag[15:0], processed[16], mapped[17], ref_id[33:18], position[64:34],
  // watermark[95:65]
  input  logic [95:0] in_tdata,
  input  logic        in_tuser,   // command
  input  logic        in_tlast,   // batch_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tag[15:0], out_processed[16], out_mapped[17], out_ref_id[33:18],
  // out_position[64:34], zero fill [71:65]
  output logic [71:0] out_tdata,
  output logic        out_tuser,  // overflowed
  output logic        out_tlast   // last
);
  import wrq_pkg::*;

  typedef enum logic {ST_IDLE, ST_REL} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  item_t            item_r, item_nxt;
  logic             own_ok_r, own_ok_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic             olast_r, olast_nxt;
  logic             oovf_r, oovf_nxt;
  entry_t           oent_r, oent_nxt;

  chain_cmd_t cmd;
  entry_t     head, second;
  logic       head_own, second_own;
  logic       accept, is_push, full;
  logic       rel0, rel1, slot_free, last_pop;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_push   = (in_tuser == CMD_PUSH);
  assign full      = (count_r == CNT_W'(CAPACITY));

  assign cmd.new_ent.tag    = in_tdata[15:0];
  assign cmd.new_ent.proc   = in_tdata[16];
  assign cmd.new_ent.mapd   = in_tdata[17];
  assign cmd.new_ent.ref_id = in_tdata[33:18];
  assign cmd.new_ent.pos    = in_tdata[64:34];

  // own marks only count when the opening request was actually stored
  assign rel0 = (count_r != '0) &&
                (item_r.flush || head_release(head, head_own && own_ok_r, item_r));
  assign rel1 = (count_r > CNT_W'(1)) &&
                (item_r.flush || head_release(second, second_own && own_ok_r, item_r));
  assign slot_free = !ovalid_r || out_tready;
  assign last_pop  = !rel1;

  assign cmd.ins = accept && is_push && !full;
  assign cmd.pop = (state_r == ST_REL) && rel0 && slot_free;

  wrq_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .count      (count_r),
    .head       (head),
    .head_own   (head_own),
    .second     (second),
    .second_own (second_own)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    item_nxt   = item_r;
    own_ok_nxt = own_ok_r;
    ovalid_nxt = ovalid_r;
    olast_nxt  = olast_r;
    oovf_nxt   = oovf_r;
    oent_nxt   = oent_r;

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt.flush  = (in_tuser == CMD_FLUSH);
          item_nxt.proc   = in_tdata[16];
          item_nxt.mapd   = in_tdata[17];
          item_nxt.ref_id = in_tdata[33:18];
          item_nxt.orig   = in_tdata[95:65];
          own_ok_nxt      = is_push && !full;
          if (is_push) begin
            if (full) ovf_nxt = 1'b1;
            else count_nxt = count_r + CNT_W'(1);
          end
          if (!is_push || in_tlast) state_nxt = ST_REL;
        end
      end
      ST_REL: begin
        if (!rel0) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          // move the head into the output register
          ovalid_nxt = 1'b1;
          oent_nxt   = head;
          olast_nxt  = last_pop;
          oovf_nxt   = ovf_r;
          count_nxt  = count_r - CNT_W'(1);
          if (last_pop) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    own_ok_r <= own_ok_nxt;
    oent_r   <= oent_nxt;
    olast_r  <= olast_nxt;
    oovf_r   <= oovf_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oovf_r;
  assign out_tdata  = {7'd0, oent_r.pos, oent_r.ref_id, oent_r.mapd, oent_r.proc,
                       oent_r.tag};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not shrink the store");

  a_ins_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the store");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0) && !cmd.ins)
    else $error("pop from empty store or during insert");

endmodule
